FILE: hdl/riec_pkg.sv
// Shared types and constants of the integer execute core.
// Item structs, opcode and condition codes, control command/status bundles.
// No dependencies.
package riec_pkg;

    localparam int unsigned PC_W = 30;
    localparam logic [PC_W-1:0] BOOT_PC_DEFAULT = 30'd1073741312;

    // register operation codes
    localparam logic [3:0] OP_MOV = 4'd0;
    localparam logic [3:0] OP_LSL = 4'd1;
    localparam logic [3:0] OP_ASR = 4'd2;
    localparam logic [3:0] OP_ROR = 4'd3;
    localparam logic [3:0] OP_AND = 4'd4;
    localparam logic [3:0] OP_ANN = 4'd5;
    localparam logic [3:0] OP_IOR = 4'd6;
    localparam logic [3:0] OP_XOR = 4'd7;
    localparam logic [3:0] OP_ADD = 4'd8;
    localparam logic [3:0] OP_SUB = 4'd9;
    localparam logic [3:0] OP_MUL = 4'd10;
    localparam logic [3:0] OP_DIV = 4'd11;

    // branch condition codes
    localparam logic [2:0] CND_MI = 3'd0;
    localparam logic [2:0] CND_EQ = 3'd1;
    localparam logic [2:0] CND_CS = 3'd2;
    localparam logic [2:0] CND_VS = 3'd3;
    localparam logic [2:0] CND_LS = 3'd4;
    localparam logic [2:0] CND_LT = 3'd5;
    localparam logic [2:0] CND_LE = 3'd6;

    // item kinds
    localparam logic KIND_INSTR = 1'b0;
    localparam logic KIND_LDATA = 1'b1;

    localparam logic [3:0] LINK_REG = 4'd15;

    typedef struct packed {
        logic        kind;
        logic [31:0] instr;
        logic [31:0] load_data;
    } riec_in_t;

    typedef struct packed {
        logic [PC_W-1:0] next_pc;
        logic            mem_valid;
        logic            mem_write;
        logic            mem_byte;
        logic [31:0]     mem_address;
        logic [31:0]     mem_wdata;
        logic            unsupported;
        logic            sequence_error;
    } riec_out_t;

    typedef struct packed {
        logic capture;
        logic rd_first;
        logic rd_second;
        logic exec;
        logic div_step;
        logic wb;
        logic out_load;
    } riec_cmd_t;

    typedef struct packed {
        logic long_mul;
        logic long_div;
        logic div_last;
        logic out_free;
    } riec_sts_t;

endpackage

FILE: hdl/riec_ctrl.sv
// Sequencing state machine of the integer execute core.
// Depends on riec_pkg for the command and status bundles.
module riec_ctrl
    import riec_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  riec_sts_t sts,
    output riec_cmd_t cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_RD1  = 7'b0000010,
        S_RD2  = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_WB   = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (item_valid) state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:  state_next = S_EXEC;
            S_EXEC:
            begin
                if (sts.long_div)      state_next = S_DIV;
                else if (sts.long_mul) state_next = S_WB;
                else                   state_next = S_OUT;
            end
            S_DIV:  if (sts.div_last) state_next = S_WB;
            S_WB:   state_next = S_OUT;
            S_OUT:  if (sts.out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // commands to the datapath
    assign item_stall    = (state_reg != S_IDLE);
    assign cmd.capture   = (state_reg == S_IDLE) && item_valid;
    assign cmd.rd_first  = (state_reg == S_RD1);
    assign cmd.rd_second = (state_reg == S_RD2);
    assign cmd.exec      = (state_reg == S_EXEC);
    assign cmd.div_step  = (state_reg == S_DIV);
    assign cmd.wb        = (state_reg == S_WB);
    assign cmd.out_load  = (state_reg == S_OUT) && sts.out_free;

endmodule

FILE: hdl/riec_dpath.sv
// Datapath of the integer execute core: register file, alu, multiplier,
// iterative divider, pc and flags, result register. Depends on riec_pkg.
module riec_dpath
    import riec_pkg::*;
#(
    parameter logic [PC_W-1:0] BOOT_PC = BOOT_PC_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  riec_in_t  item,
    input  riec_cmd_t cmd,
    output riec_sts_t sts,
    output logic      result_valid,
    input  logic      result_stall,
    output riec_out_t result
);

    // architectural state
    logic [PC_W-1:0] pc_reg, pc_next;
    logic [31:0]     h_reg, h_next;
    logic [3:0]      flags_reg, flags_next;
    logic            pend_reg, pend_next;
    logic [3:0]      ldest_reg, ldest_next;
    logic            lbyte_reg, lbyte_next;
    logic [1:0]      llane_reg, llane_next;

    // register file
    logic [31:0] rf_mem [16];
    logic [15:0] rf_valid_reg;
    logic [31:0] rdata_reg;
    logic        rd_valid_reg;
    logic [3:0]  rd_addr;
    logic [31:0] rd_val;
    logic        wr_en;
    logic [3:0]  wr_addr;
    logic [31:0] wr_data;

    // item and operands
    logic        kind_reg;
    logic [31:0] ir_reg;
    logic [31:0] ld_reg;
    logic [31:0] opb_reg;

    // multiply and divide
    logic [63:0] prod_reg;
    logic        wb_div_reg;
    logic [31:0] dq_reg;
    logic [30:0] dr_reg;
    logic [30:0] dd_reg;
    logic        dneg_reg;
    logic [4:0]  dcnt_reg;

    // result
    riec_out_t res_reg, res_next;
    riec_out_t out_reg;
    logic      out_valid_reg;

    // decode helpers
    logic [31:0] bv, sec, cv, res_alu, asr_v, dividend;
    logic [3:0]  op;
    logic [4:0]  sh;
    logic [32:0] sum33, dif33;
    logic        cin, seq_err, taken, cond;
    logic [31:0] maddr, ld_val;
    logic [PC_W-1:0] pc_inc, br_off;
    logic signed [32:0] ma, mb;
    logic signed [65:0] mp;
    logic [31:0] trial;
    logic        ge;
    logic [31:0] div_q, div_h;
    logic        start_div, start_mul;

    assign bv     = opb_reg;
    assign rd_val = rd_valid_reg ? rdata_reg : 32'd0;
    assign sec    = rd_val;
    assign op     = ir_reg[19:16];
    assign cv     = !ir_reg[30] ? sec :
                    (!ir_reg[28] ? {16'h0000, ir_reg[15:0]} : {16'hFFFF, ir_reg[15:0]});
    assign sh     = cv[4:0];
    assign cin    = ir_reg[29] & flags_reg[1];
    assign sum33  = {1'b0, bv} + {1'b0, cv} + {32'd0, cin};
    assign dif33  = {1'b0, bv} - {1'b0, cv} - {32'd0, cin};
    assign asr_v  = 32'($signed(bv) >>> sh);
    assign seq_err = (kind_reg != pend_reg);
    assign pc_inc = pc_reg + 1'b1;
    assign br_off = {{(PC_W-24){ir_reg[23]}}, ir_reg[23:0]};
    assign maddr  = bv + {{12{ir_reg[19]}}, ir_reg[19:0]};
    assign ld_val = lbyte_reg ? {24'd0, 8'(ld_reg >> {llane_reg, 3'b000})} : ld_reg;
    assign dividend = (!ir_reg[29] && bv[31]) ? 32'd0 - bv : bv;

    // signed or unsigned product of 33-bit extended operands
    assign ma = $signed({~ir_reg[29] & bv[31], bv});
    assign mb = $signed({~ir_reg[29] & cv[31], cv});
    assign mp = ma * mb;

    // one restoring divide step
    assign trial = {dr_reg, dq_reg[31]};
    assign ge    = (trial >= {1'b0, dd_reg});

    // floored quotient and remainder fixup
    always_comb
    begin
        div_q = dq_reg;
        div_h = {1'b0, dr_reg};
        if (dneg_reg)
        begin
            if (dr_reg == 31'd0)
            begin
                div_q = 32'd0 - dq_reg;
                div_h = 32'd0;
            end
            else
            begin
                div_q = ~dq_reg;
                div_h = {1'b0, dd_reg - dr_reg};
            end
        end
    end

    // branch condition
    always_comb
    begin
        case (ir_reg[26:24])
            CND_MI:  cond = flags_reg[3];
            CND_EQ:  cond = flags_reg[2];
            CND_CS:  cond = flags_reg[1];
            CND_VS:  cond = flags_reg[0];
            CND_LS:  cond = flags_reg[1] | flags_reg[2];
            CND_LT:  cond = flags_reg[3] ^ flags_reg[0];
            CND_LE:  cond = (flags_reg[3] ^ flags_reg[0]) | flags_reg[2];
            default: cond = 1'b1;
        endcase
        taken = cond ^ ir_reg[27];
    end

    // simple alu result
    always_comb
    begin
        case (op)
            OP_MOV:
            begin
                if (!ir_reg[29])     res_alu = cv;
                else if (ir_reg[30]) res_alu = {cv[15:0], 16'h0000};
                else if (ir_reg[28]) res_alu = {flags_reg, 20'd0, 8'hD0};
                else                 res_alu = h_reg;
            end
            OP_LSL:  res_alu = bv << sh;
            OP_ASR:  res_alu = asr_v;
            OP_ROR:  res_alu = 32'({bv, bv} >> sh);
            OP_AND:  res_alu = bv & cv;
            OP_ANN:  res_alu = bv & ~cv;
            OP_IOR:  res_alu = bv | cv;
            OP_XOR:  res_alu = bv ^ cv;
            OP_ADD:  res_alu = sum33[31:0];
            OP_SUB:  res_alu = dif33[31:0];
            default: res_alu = 32'd0;
        endcase
    end

    // execute and write-back decisions
    always_comb
    begin
        pc_next    = pc_reg;
        h_next     = h_reg;
        flags_next = flags_reg;
        pend_next  = pend_reg;
        ldest_next = ldest_reg;
        lbyte_next = lbyte_reg;
        llane_next = llane_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_addr    = ir_reg[27:24];
        wr_data    = res_alu;
        start_div  = 1'b0;
        start_mul  = 1'b0;
        if (cmd.exec)
        begin
            res_next = '0;
            if (seq_err)
                res_next.sequence_error = 1'b1;
            else if (kind_reg == KIND_LDATA)
            begin
                wr_en     = 1'b1;
                wr_addr   = ldest_reg;
                wr_data   = ld_val;
                pend_next = 1'b0;
            end
            else
            begin
                pc_next = pc_inc;
                if (!ir_reg[31])
                begin
                    // register operations
                    if (op == OP_MUL)
                        start_mul = 1'b1;
                    else if (op == OP_DIV)
                    begin
                        if (cv == 32'd0 || cv[31])
                            res_next.unsupported = 1'b1;
                        else
                            start_div = 1'b1;
                    end
                    else if (op > OP_DIV)
                        res_next.unsupported = 1'b1;
                    else
                    begin
                        wr_en = 1'b1;
                        if (op == OP_ADD)
                            flags_next[1:0] = {sum33[32],
                                ((sum33[31:0] ^ cv) & (sum33[31:0] ^ bv)) >> 31 != 32'd0};
                        if (op == OP_SUB)
                            flags_next[1:0] = {dif33[32],
                                ((bv ^ cv) & (dif33[31:0] ^ bv)) >> 31 != 32'd0};
                    end
                end
                else if (!ir_reg[30])
                begin
                    // load and store
                    res_next.mem_valid   = 1'b1;
                    res_next.mem_byte    = ir_reg[28];
                    res_next.mem_address = maddr;
                    if (!ir_reg[29])
                    begin
                        pend_next  = 1'b1;
                        ldest_next = ir_reg[27:24];
                        lbyte_next = ir_reg[28];
                        llane_next = maddr[1:0];
                    end
                    else
                    begin
                        res_next.mem_write = 1'b1;
                        res_next.mem_wdata = ir_reg[28] ?
                            ({24'd0, sec[7:0]} << {maddr[1:0], 3'b000}) : sec;
                    end
                end
                else if (taken)
                begin
                    // branches, link holds the advanced pc
                    pc_next = ir_reg[29] ? pc_inc + br_off : sec[31:2];
                    if (ir_reg[28])
                    begin
                        wr_en   = 1'b1;
                        wr_addr = LINK_REG;
                        wr_data = {pc_inc, 2'b00};
                    end
                end
            end
            res_next.next_pc = pc_next;
        end
        if (cmd.wb)
        begin
            wr_en   = 1'b1;
            wr_data = wb_div_reg ? div_q : prod_reg[31:0];
            h_next  = wb_div_reg ? div_h : prod_reg[63:32];
        end
        if (wr_en)
            flags_next[3:2] = {wr_data[31], wr_data == 32'd0};
    end

    assign rd_addr = cmd.rd_first ? ir_reg[23:20] :
                     (ir_reg[31] && !ir_reg[30]) ? ir_reg[27:24] : ir_reg[3:0];

    // register file storage
    always_ff @(posedge clk)
    begin
        if (wr_en)
            rf_mem[wr_addr] <= wr_data;
        rdata_reg <= rf_mem[rd_addr];
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= BOOT_PC;
            h_reg         <= 32'd0;
            flags_reg     <= 4'd0;
            pend_reg      <= 1'b0;
            ldest_reg     <= 4'd0;
            lbyte_reg     <= 1'b0;
            llane_reg     <= 2'd0;
            rf_valid_reg  <= 16'd0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg       <= pc_next;
            h_reg        <= h_next;
            flags_reg    <= flags_next;
            pend_reg     <= pend_next;
            ldest_reg    <= ldest_next;
            lbyte_reg    <= lbyte_next;
            llane_reg    <= llane_next;
            rd_valid_reg <= rf_valid_reg[rd_addr];
            if (wr_en)
                rf_valid_reg[wr_addr] <= 1'b1;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (!result_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
        if (cmd.capture)
        begin
            kind_reg <= item.kind;
            ir_reg   <= item.instr;
            ld_reg   <= item.load_data;
        end
        if (cmd.rd_second)
            opb_reg <= rd_val;
        if (start_mul)
        begin
            prod_reg   <= mp[63:0];
            wb_div_reg <= 1'b0;
        end
        if (start_div)
        begin
            wb_div_reg <= 1'b1;
            dq_reg     <= dividend;
            dr_reg     <= 31'd0;
            dd_reg     <= cv[30:0];
            dneg_reg   <= !ir_reg[29] && bv[31];
            dcnt_reg   <= 5'd0;
        end
        else if (cmd.div_step)
        begin
            dq_reg   <= {dq_reg[30:0], ge};
            dr_reg   <= ge ? 31'(trial - {1'b0, dd_reg}) : trial[30:0];
            dcnt_reg <= dcnt_reg + 1'b1;
        end
        if (cmd.out_load)
            out_reg <= res_reg;
    end

    assign sts.long_mul = start_mul;
    assign sts.long_div = start_div;
    assign sts.div_last = (dcnt_reg == 5'd31);
    assign sts.out_free = !out_valid_reg || !result_stall;

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

FILE: hdl/risc_integer_execute_core.sv
// Integer execute core: one instruction or load-data item at a time, one result each.
// Top level; instantiates riec_ctrl and riec_dpath, depends on riec_pkg.
// An item passes from acceptance through the states RD1, RD2 and EXEC to its result
// register (register file reads through one registered port take RD1 and RD2); a
// multiply adds WB for its registered product, and a divide adds DIV (one quotient bit
// per cycle, 32 steps) and then WB. The result register loads only once the output
// register is free of result_stall, and the next item is accepted in the cycle after. A
// finished result waits in the output register while the next item is taken; a load
// is answered by a load-data item that carries the returned word.
module risc_integer_execute_core
    import riec_pkg::*;
#(
    parameter logic [PC_W-1:0] BOOT_PC = BOOT_PC_DEFAULT
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  riec_in_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output riec_out_t result
);

    riec_cmd_t cmd;
    riec_sts_t sts;

    // sequencer
    riec_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    // datapath
    riec_dpath #(
        .BOOT_PC (BOOT_PC)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .sts          (sts),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

`ifndef SYNTHESIS
    // one item in flight at a time
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("item accepted while busy");

    // a sequence error never issues a memory request
    a_seq_no_mem: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !(result.sequence_error && result.mem_valid))
        else $error("memory request on sequence error");

    // writes are always requests
    a_write_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.mem_write) |-> result.mem_valid)
        else $error("write without request");
`endif

endmodule

FILE: dv/risc_integer_execute_core_tb.sv
// Testbench of the integer execute core: directed and random instruction streams.
// Predicts each result with its own model of registers, flags, H and pc; depends on riec_pkg.
module risc_integer_execute_core_tb;
    import riec_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 100;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    riec_in_t  item;
    logic      result_valid;
    logic      result_stall;
    riec_out_t result;

    // predictor state
    logic [PC_W-1:0] pc_q;
    logic [31:0]     regs_q [16];
    logic [31:0]     h_q;
    logic [3:0]      nzcv_q;
    logic            ld_wait_q;
    logic [3:0]      ld_dest_q;
    logic            ld_byte_q;
    logic [1:0]      ld_lane_q;

    riec_out_t expected_results [$];
    int        error_count;
    int        idle_cycles;
    bit        drain_on;

    risc_integer_execute_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // write a register and update n and z
    function automatic void write_gpr(input logic [3:0] idx, input logic [31:0] val);
        regs_q[idx] = val;
        nzcv_q[3] = val[31];
        nzcv_q[2] = (val == 32'd0);
    endfunction

    // register operation, returns 1 when unsupported
    function automatic bit exec_alu(input logic [31:0] ir);
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] res;
        logic [4:0]  s;
        logic [32:0] wide;
        logic [63:0] prod;
        logic [31:0] mag;
        logic [31:0] q;
        logic [31:0] r;
        logic        cin;
        b = regs_q[ir[23:20]];
        if (!ir[30]) c = regs_q[ir[3:0]];
        else if (!ir[28]) c = {16'd0, ir[15:0]};
        else c = {16'hFFFF, ir[15:0]};
        s = c[4:0];
        res = '0;
        case (ir[19:16])
            OP_MOV:
            begin
                if (!ir[29]) res = c;
                else if (ir[30]) res = c << 16;
                else if (ir[28]) res = {nzcv_q, 20'd0, 8'hD0};
                else res = h_q;
            end
            OP_LSL: res = b << s;
            OP_ASR: res = $unsigned($signed(b) >>> s);
            OP_ROR: res = (s == 0) ? b : ((b >> s) | (b << (6'd32 - s)));
            OP_AND: res = b & c;
            OP_ANN: res = b & ~c;
            OP_IOR: res = b | c;
            OP_XOR: res = b ^ c;
            OP_ADD:
            begin
                cin = ir[29] & nzcv_q[1];
                wide = {1'b0, b} + {1'b0, c} + cin;
                res = wide[31:0];
                nzcv_q[1] = wide[32];
                nzcv_q[0] = (res[31] ^ c[31]) & (res[31] ^ b[31]);
            end
            OP_SUB:
            begin
                cin = ir[29] & nzcv_q[1];
                res = b - c - cin;
                nzcv_q[1] = ({1'b0, b} < ({1'b0, c} + cin));
                nzcv_q[0] = (b[31] ^ c[31]) & (res[31] ^ b[31]);
            end
            OP_MUL:
            begin
                if (ir[29]) prod = {32'd0, b} * {32'd0, c};
                else prod = $unsigned($signed({{32{b[31]}}, b}) * $signed({{32{c[31]}}, c}));
                res = prod[31:0];
                h_q = prod[63:32];
            end
            OP_DIV:
            begin
                if (c == 0 || c[31]) return 1'b1;
                if (ir[29] || !b[31])
                begin
                    res = b / c;
                    h_q = b % c;
                end
                else
                begin
                    mag = -b;
                    q = mag / c;
                    r = mag % c;
                    if (r == 0)
                    begin
                        res = -q;
                        h_q = '0;
                    end
                    else
                    begin
                        res = -q - 1;
                        h_q = c - r;
                    end
                end
            end
            default: return 1'b1;
        endcase
        write_gpr(ir[27:24], res);
        return 1'b0;
    endfunction

    function automatic bit cond_taken(input logic [31:0] ir);
        logic n;
        logic z;
        logic c;
        logic v;
        logic t;
        {n, z, c, v} = nzcv_q;
        case (ir[26:24])
            CND_MI: t = n;
            CND_EQ: t = z;
            CND_CS: t = c;
            CND_VS: t = v;
            CND_LS: t = c | z;
            CND_LT: t = n ^ v;
            CND_LE: t = (n ^ v) | z;
            default: t = 1'b1;
        endcase
        return t ^ ir[27];
    endfunction

    // predict the result of one item
    task automatic predict_item(input riec_in_t it);
        riec_out_t o;
        logic [31:0] ir;
        logic [31:0] off;
        logic [31:0] val;
        logic [PC_W-1:0] target;
        o = '0;
        ir = it.instr;
        if (it.kind != ld_wait_q) o.sequence_error = 1'b1;
        else if (it.kind == KIND_LDATA)
        begin
            val = it.load_data;
            if (ld_byte_q) val = (it.load_data >> (ld_lane_q * 8)) & 32'hFF;
            write_gpr(ld_dest_q, val);
            ld_wait_q = 1'b0;
        end
        else
        begin
            pc_q = pc_q + 1'b1;
            if (!ir[31]) o.unsupported = exec_alu(ir);
            else if (!ir[30])
            begin
                off = {{12{ir[19]}}, ir[19:0]};
                o.mem_address = regs_q[ir[23:20]] + off;
                o.mem_valid = 1'b1;
                o.mem_byte = ir[28];
                if (!ir[29])
                begin
                    ld_wait_q = 1'b1;
                    ld_dest_q = ir[27:24];
                    ld_byte_q = ir[28];
                    ld_lane_q = o.mem_address[1:0];
                end
                else
                begin
                    o.mem_write = 1'b1;
                    if (ir[28]) o.mem_wdata = {24'd0, regs_q[ir[27:24]][7:0]}
                        << (o.mem_address[1:0] * 8);
                    else o.mem_wdata = regs_q[ir[27:24]];
                end
            end
            else if (cond_taken(ir))
            begin
                if (!ir[29]) target = regs_q[ir[3:0]][31:2];
                else target = pc_q + {{6{ir[23]}}, ir[23:0]};
                if (ir[28]) write_gpr(LINK_REG, {pc_q, 2'b00});
                pc_q = target;
            end
        end
        o.next_pc = pc_q;
        expected_results.push_back(o);
    endtask

    // random gap, mostly short and now and then long
    function automatic int rand_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // send one item and predict it at acceptance; valid stays high until a gap
    task automatic send_item(input logic kind, input logic [31:0] ir, input logic [31:0] ld);
        riec_in_t it;
        int gap;
        it.kind = kind;
        it.instr = ir;
        it.load_data = ld;
        gap = rand_gap();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        @(posedge clk);
        while (item_stall) @(posedge clk);
        predict_item(it);
    endtask

    task automatic send_instr(input logic [31:0] ir);
        send_item(KIND_INSTR, ir, $urandom);
    endtask

    // instruction encoders
    function automatic logic [31:0] reg_op(input logic [3:0] op, input logic [3:0] a,
                                           input logic [3:0] b, input logic [2:0] quv,
                                           input logic [15:0] cfield);
        return {1'b0, quv, a, b, op, cfield};
    endfunction

    function automatic logic [31:0] mem_op(input bit store, input bit byte_acc,
                                           input logic [3:0] a, input logic [3:0] b,
                                           input logic [19:0] off);
        return {2'b10, store, byte_acc, a, b, off};
    endfunction

    task automatic send_load(input bit byte_acc, input logic [3:0] a, input logic [3:0] b,
                             input logic [19:0] off, input logic [31:0] data);
        send_instr(mem_op(1'b0, byte_acc, a, b, off));
        send_item(KIND_LDATA, $urandom, data);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // directed: extremes, every operation, special cases
    task automatic test_directed();
        // load extremes into registers
        send_load(1'b0, 4'd1, 4'd0, 20'h00000, 32'hFFFFFFFF);
        send_load(1'b0, 4'd2, 4'd0, 20'h00004, 32'h80000000);
        send_load(1'b1, 4'd3, 4'd0, 20'h00003, 32'hA5B6C7D8);
        send_instr(reg_op(OP_MOV, 4'd4, 4'd0, 3'b110, 16'hFFFF));
        for (int op = 0; op <= 15; op++)
            send_instr(reg_op(op[3:0], 4'd5, 4'd1, 3'b000, 16'h0002));
        send_instr(reg_op(OP_ADD, 4'd6, 4'd1, 3'b010, 16'h0001));
        send_instr(reg_op(OP_SUB, 4'd6, 4'd2, 3'b010, 16'h0001));
        send_instr(reg_op(OP_MOV, 4'd7, 4'd0, 3'b001, 16'h0000));
        send_instr(reg_op(OP_DIV, 4'd7, 4'd1, 3'b100, 16'h0000));
        send_instr(reg_op(OP_DIV, 4'd7, 4'd2, 3'b100, 16'h0007));
        // sequence errors both ways
        send_item(KIND_LDATA, 32'd0, 32'h12345678);
        send_instr(mem_op(1'b0, 1'b0, 4'd8, 4'd1, 20'h80000));
        send_instr(32'hFFFFFFFF);
        send_item(KIND_LDATA, 32'd0, 32'h0);
        send_instr(mem_op(1'b1, 1'b1, 4'd3, 4'd1, 20'h7FFFF));
        // branch through r15 with link, and an offset branch
        send_instr({4'b1101, 1'b0, 3'd7, 20'd0, 4'd15});
        send_instr({4'b1111, 1'b0, 3'd7, 24'h800000});
    endtask

    function automatic logic [31:0] rand_instr();
        logic [31:0] ir;
        int p;
        ir = $urandom;
        p = $urandom_range(0, 99);
        if (p < 55) ir[31] = 1'b0;
        else if (p < 80) ir[31:30] = 2'b10;
        else ir[31:30] = 2'b11;
        if (!ir[31] && $urandom_range(0, 3) != 0) ir[19:16] = 4'($urandom_range(0, 11));
        if (!ir[31] && $urandom_range(0, 1)) ir[15:0] = 16'($urandom_range(0, 40));
        if (ir[31:30] == 2'b10 && $urandom_range(0, 1)) ir[19:0] = 20'($urandom_range(0, 15));
        return ir;
    endfunction

    // random stream, loads answered except for occasional broken sequences
    task automatic test_random(input int count);
        logic [31:0] ir;
        for (int i = 0; i < count; i++)
        begin
            ir = rand_instr();
            send_instr(ir);
            if (ir[31:29] == 3'b100)
            begin
                if ($urandom_range(0, 19) == 0) send_instr($urandom);
                send_item(KIND_LDATA, $urandom, $urandom);
            end
            else if ($urandom_range(0, 39) == 0)
                send_item(KIND_LDATA, $urandom, $urandom);
            if (i == count / 2) wait_idle();
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        riec_out_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result %h", result);
                error_count++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (result.next_pc !== e.next_pc)
                begin
                    $error("next_pc exp %h got %h", e.next_pc, result.next_pc);
                    error_count++;
                end
                if (result.mem_valid !== e.mem_valid)
                begin
                    $error("mem_valid exp %h got %h", e.mem_valid, result.mem_valid);
                    error_count++;
                end
                if (result.mem_write !== e.mem_write)
                begin
                    $error("mem_write exp %h got %h", e.mem_write, result.mem_write);
                    error_count++;
                end
                if (result.mem_byte !== e.mem_byte)
                begin
                    $error("mem_byte exp %h got %h", e.mem_byte, result.mem_byte);
                    error_count++;
                end
                if (result.mem_address !== e.mem_address)
                begin
                    $error("mem_address exp %h got %h", e.mem_address, result.mem_address);
                    error_count++;
                end
                if (result.mem_wdata !== e.mem_wdata)
                begin
                    $error("mem_wdata exp %h got %h", e.mem_wdata, result.mem_wdata);
                    error_count++;
                end
                if (result.unsupported !== e.unsupported)
                begin
                    $error("unsupported exp %h got %h", e.unsupported, result.unsupported);
                    error_count++;
                end
                if (result.sequence_error !== e.sequence_error)
                begin
                    $error("sequence_error exp %h got %h", e.sequence_error,
                           result.sequence_error);
                    error_count++;
                end
            end
        end
    end

    // receiver stall pattern
    initial
    begin
        int gap;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            gap = rand_gap();
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            result_stall <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    // watchdog on cycles without any accepted item or result
    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall) || drain_on)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        idle_cycles = 0;
        drain_on = 1'b0;
        rst_n = 1'b0;
        item_valid <= 1'b0;
        item <= '0;
        pc_q = BOOT_PC_DEFAULT;
        for (int i = 0; i < 16; i++) regs_q[i] = '0;
        h_q = '0;
        nzcv_q = '0;
        ld_wait_q = 1'b0;
        ld_dest_q = '0;
        ld_byte_q = 1'b0;
        ld_lane_q = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(680);
        // answer a load left waiting at the end
        if (ld_wait_q) send_item(KIND_LDATA, 32'd0, $urandom);
        item_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        drain_on = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
